FILE: src/cau_pkg.sv
// cau_pkg: words, operation codes and helpers for the complex arithmetic unit
// used by every file of the block, depends on nothing
`default_nettype none
package cau_pkg;

  localparam logic [2:0] CMD_ADD  = 3'd0;
  localparam logic [2:0] CMD_SUB  = 3'd1;
  localparam logic [2:0] CMD_MUL  = 3'd2;
  localparam logic [2:0] CMD_DIV  = 3'd3;
  localparam logic [2:0] CMD_CMP  = 3'd4;
  localparam logic [2:0] CMD_CONJ = 3'd5;

  // quotient bits produced by the divider chain, one per cell
  localparam int QBITS = 32;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic               is_equal;
    logic               div_zero;
    logic               overflowed;
  } cau_out_t;

  // results of the ops that need no multiplier, carried alongside
  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        eq;
    logic        ovf;
  } cau_simple_t;

  typedef struct packed {
    logic [2:0]         cmd;
    cau_simple_t        simple;
    logic signed [63:0] p_rr;
    logic signed [63:0] p_ii;
    logic signed [63:0] p_ri;
    logic signed [63:0] p_ir;
    logic signed [63:0] s_rr;
    logic signed [63:0] s_ii;
  } cau_prod_t;

  typedef struct packed {
    logic [2:0]  cmd;
    cau_simple_t simple;
    logic [63:0] d;
    logic [64:0] nre;
    logic [64:0] nim;
    logic [64:0] mre;
    logic [64:0] mim;
  } cau_sum_t;

  typedef struct packed {
    logic [2:0]  cmd;
    cau_simple_t simple;
    logic        dz;
    logic [63:0] d;
    logic        neg_re;
    logic        neg_im;
    logic        big_re;
    logic        big_im;
    logic [63:0] rem_re;
    logic [63:0] rem_im;
    logic [31:0] low_re;
    logic [31:0] low_im;
    logic [31:0] q_re;
    logic [31:0] q_im;
  } cau_cell_t;

  // 33-bit signed sum to {overflow, saturated 32-bit value}
  function automatic logic [32:0] sat33(input logic [32:0] s);
    logic [32:0] r;
    if (s[32] != s[31]) begin
      r = s[32] ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7fff_ffff};
    end else begin
      r = {1'b0, s[31:0]};
    end
    return r;
  endfunction

  // magnitude of a 65-bit two's complement value, at most 2^63
  function automatic logic [63:0] mag65(input logic [64:0] x);
    logic [64:0] n;
    n = 65'd0 - x;
    return x[64] ? n[63:0] : x[63:0];
  endfunction

  // sign and magnitude to {overflow, saturated 32-bit value}
  function automatic logic [32:0] sat_sm(input logic neg, input logic big,
                                         input logic [63:0] v);
    logic        o;
    logic [31:0] r;
    o = big || (neg ? (v > 64'h8000_0000) : (v > 64'h7fff_ffff));
    if (o) begin
      r = neg ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      r = neg ? (32'd0 - v[31:0]) : v[31:0];
    end
    return {o, r};
  endfunction

endpackage
`default_nettype wire

FILE: src/cau_div_cell.sv
// cau_div_cell: one restoring division step for both result parts
// depends on cau_pkg
`default_nettype none
module cau_div_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire logic              in_valid,
  input  wire cau_pkg::cau_cell_t in_tok,
  output logic                   out_valid,
  output cau_pkg::cau_cell_t     out_tok
);

  cau_pkg::cau_cell_t tok_next;
  logic [64:0] t_re, t_im, dif_re, dif_im;
  logic        ge_re, ge_im;

  always_comb begin
    tok_next = in_tok;
    t_re     = {in_tok.rem_re, in_tok.low_re[31]};
    t_im     = {in_tok.rem_im, in_tok.low_im[31]};
    dif_re   = t_re - {1'b0, in_tok.d};
    dif_im   = t_im - {1'b0, in_tok.d};
    ge_re    = t_re >= {1'b0, in_tok.d};
    ge_im    = t_im >= {1'b0, in_tok.d};
    tok_next.rem_re = ge_re ? dif_re[63:0] : t_re[63:0];
    tok_next.rem_im = ge_im ? dif_im[63:0] : t_im[63:0];
    tok_next.low_re = {in_tok.low_re[30:0], 1'b0};
    tok_next.low_im = {in_tok.low_im[30:0], 1'b0};
    tok_next.q_re   = {in_tok.q_re[30:0], ge_re};
    tok_next.q_im   = {in_tok.q_im[30:0], ge_im};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tok <= tok_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/complex_arithmetic_unit.sv
// complex_arithmetic_unit: complex add, subtract, multiply, divide, compare, conjugate
// depends on cau_pkg and cau_div_cell
//
// One word is taken per cycle while op_stall is low, and one result word leaves
// per cycle while res_stall is low. Each word passes 37 register stages: input,
// products, sums, divide setup, 32 divider cells (one quotient bit each, both
// parts at once) and the output register. Every op runs the same path, which
// keeps results in order. A stage loads whenever it is empty or the stage
// after it moves, so stalls on the result side fill bubbles before op_stall
// rises.
`default_nettype none
module complex_arithmetic_unit #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             op_valid,
  output logic                  op_stall,
  input  wire cau_pkg::cau_in_t op,
  output logic                  res_valid,
  input  wire logic             res_stall,
  output cau_pkg::cau_out_t     res
);

  localparam int NW = 64 + FRAC_BITS;

  logic vA, vB, vC, vD;
  logic ldA, ldB, ldC, ldD, ldE;
  cau_pkg::cau_in_t   stA;
  cau_pkg::cau_prod_t stB, stB_next;
  cau_pkg::cau_sum_t  stC, stC_next;
  cau_pkg::cau_cell_t stD_next;
  cau_pkg::cau_cell_t stD;
  cau_pkg::cau_out_t  stE_next;

  logic [cau_pkg::QBITS-1:0] cell_v, cell_ld;
  cau_pkg::cau_cell_t        cell_tok [cau_pkg::QBITS];

  // load chain, back to front
  assign ldE = !res_valid || !res_stall;
  assign cell_ld[cau_pkg::QBITS-1] = !cell_v[cau_pkg::QBITS-1] || ldE;
  for (genvar k = 0; k < cau_pkg::QBITS - 1; k++) begin : g_ld
    assign cell_ld[k] = !cell_v[k] || cell_ld[k+1];
  end
  assign ldD = !vD || cell_ld[0];
  assign ldC = !vC || ldD;
  assign ldB = !vB || ldC;
  assign ldA = !vA || ldB;
  assign op_stall = !ldA;

  always_ff @(posedge clk) begin
    if (rst) begin
      vA <= 1'b0;
      vB <= 1'b0;
      vC <= 1'b0;
      vD <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (ldA) vA <= op_valid;
      if (ldB) vB <= vA;
      if (ldC) vC <= vB;
      if (ldD) vD <= vC;
      if (ldE) res_valid <= cell_v[cau_pkg::QBITS-1];
    end
  end

  // products and the simple ops
  logic [32:0] sr, si;
  always_comb begin
    stB_next      = '0;
    stB_next.cmd  = stA.cmd;
    stB_next.p_rr = stA.a_re * stA.b_re;
    stB_next.p_ii = stA.a_im * stA.b_im;
    stB_next.p_ri = stA.a_re * stA.b_im;
    stB_next.p_ir = stA.a_im * stA.b_re;
    stB_next.s_rr = stA.b_re * stA.b_re;
    stB_next.s_ii = stA.b_im * stA.b_im;
    sr = '0;
    si = '0;
    unique case (stA.cmd)
      cau_pkg::CMD_ADD: begin
        sr = cau_pkg::sat33({stA.a_re[31], stA.a_re} + {stA.b_re[31], stA.b_re});
        si = cau_pkg::sat33({stA.a_im[31], stA.a_im} + {stA.b_im[31], stA.b_im});
      end
      cau_pkg::CMD_SUB: begin
        sr = cau_pkg::sat33({stA.a_re[31], stA.a_re} - {stA.b_re[31], stA.b_re});
        si = cau_pkg::sat33({stA.a_im[31], stA.a_im} - {stA.b_im[31], stA.b_im});
      end
      cau_pkg::CMD_CONJ: begin
        sr = {1'b0, stA.a_re};
        si = cau_pkg::sat33(33'd0 - {stA.a_im[31], stA.a_im});
      end
      default: begin
        sr = '0;
        si = '0;
      end
    endcase
    stB_next.simple.re  = sr[31:0];
    stB_next.simple.im  = si[31:0];
    stB_next.simple.ovf = sr[32] | si[32];
    stB_next.simple.eq  = (stA.cmd == cau_pkg::CMD_CMP) &&
                          (stA.a_re == stA.b_re) && (stA.a_im == stA.b_im);
  end

  // sums of products
  always_comb begin
    stC_next        = '0;
    stC_next.cmd    = stB.cmd;
    stC_next.simple = stB.simple;
    stC_next.d      = stB.s_rr + stB.s_ii;
    stC_next.nre    = {stB.p_rr[63], stB.p_rr} + {stB.p_ii[63], stB.p_ii};
    stC_next.nim    = {stB.p_ir[63], stB.p_ir} - {stB.p_ri[63], stB.p_ri};
    stC_next.mre    = {stB.p_rr[63], stB.p_rr} - {stB.p_ii[63], stB.p_ii};
    stC_next.mim    = {stB.p_ri[63], stB.p_ri} + {stB.p_ir[63], stB.p_ir};
  end

  // multiply saturation and divider setup
  logic [63:0]   mg_re, mg_im, dg_re, dg_im;
  logic [NW-1:0] n_re, n_im;
  logic [32:0]   mr, mi;
  always_comb begin
    mg_re = cau_pkg::mag65(stC.mre);
    mg_im = cau_pkg::mag65(stC.mim);
    mr    = cau_pkg::sat_sm(stC.mre[64], 1'b0, mg_re >> FRAC_BITS);
    mi    = cau_pkg::sat_sm(stC.mim[64], 1'b0, mg_im >> FRAC_BITS);
    dg_re = cau_pkg::mag65(stC.nre);
    dg_im = cau_pkg::mag65(stC.nim);
    n_re  = NW'(dg_re) << FRAC_BITS;
    n_im  = NW'(dg_im) << FRAC_BITS;
    stD_next        = '0;
    stD_next.cmd    = stC.cmd;
    stD_next.simple = stC.simple;
    if (stC.cmd == cau_pkg::CMD_MUL) begin
      stD_next.simple.re  = mr[31:0];
      stD_next.simple.im  = mi[31:0];
      stD_next.simple.ovf = mr[32] | mi[32];
    end
    stD_next.dz     = (stC.d == 64'd0);
    stD_next.d      = stC.d;
    stD_next.neg_re = stC.nre[64];
    stD_next.neg_im = stC.nim[64];
    stD_next.rem_re = 64'(n_re[NW-1:32]);
    stD_next.rem_im = 64'(n_im[NW-1:32]);
    // quotient above 32 bits: saturates whatever the low bits are
    stD_next.big_re = 64'(n_re[NW-1:32]) >= stC.d;
    stD_next.big_im = 64'(n_im[NW-1:32]) >= stC.d;
    stD_next.low_re = n_re[31:0];
    stD_next.low_im = n_im[31:0];
  end

  always_ff @(posedge clk) begin
    if (ldA) stA <= op;
    if (ldB) stB <= stB_next;
    if (ldC) stC <= stC_next;
    if (ldD) stD <= stD_next;
    if (ldE) res <= stE_next;
  end

  for (genvar k = 0; k < cau_pkg::QBITS; k++) begin : g_cell
    if (k == 0) begin : g_first
      cau_div_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .load     (cell_ld[k]),
        .in_valid (vD),
        .in_tok   (stD),
        .out_valid(cell_v[k]),
        .out_tok  (cell_tok[k])
      );
    end else begin : g_next
      cau_div_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .load     (cell_ld[k]),
        .in_valid (cell_v[k-1]),
        .in_tok   (cell_tok[k-1]),
        .out_valid(cell_v[k]),
        .out_tok  (cell_tok[k])
      );
    end
  end

  // final selection
  cau_pkg::cau_cell_t last;
  logic [32:0] qr, qi;
  always_comb begin
    last = cell_tok[cau_pkg::QBITS-1];
    qr   = cau_pkg::sat_sm(last.neg_re, last.big_re, 64'(last.q_re));
    qi   = cau_pkg::sat_sm(last.neg_im, last.big_im, 64'(last.q_im));
    stE_next = '0;
    if (last.cmd == cau_pkg::CMD_DIV) begin
      if (last.dz) begin
        stE_next.div_zero = 1'b1;
      end else begin
        stE_next.res_re     = qr[31:0];
        stE_next.res_im     = qi[31:0];
        stE_next.overflowed = qr[32] | qi[32];
      end
    end else begin
      stE_next.res_re     = last.simple.re;
      stE_next.res_im     = last.simple.im;
      stE_next.is_equal   = last.simple.eq;
      stE_next.overflowed = last.simple.ovf;
    end
  end

endmodule
`default_nettype wire

FILE: src/cau_checker.sv
// cau_checker: port-level checks for complex_arithmetic_unit, bound to the top
// depends on cau_pkg
`default_nettype none
module cau_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              res_valid,
  input wire logic              res_stall,
  input wire cau_pkg::cau_out_t res
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result word changed");

  a_cmp_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.is_equal |-> res.res_re == 32'sd0 && res.res_im == 32'sd0
      && !res.div_zero && !res.overflowed)
    else $error("compare word carries other fields");

  a_dz_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.div_zero |-> res.res_re == 32'sd0 && res.res_im == 32'sd0
      && !res.overflowed)
    else $error("zero divisor word not cleared");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
  .clk      (clk),
  .rst      (rst),
  .res_valid(res_valid),
  .res_stall(res_stall),
  .res      (res)
);
`default_nettype wire
